// File: src/afdr_pkg.sv
// ----------------------------------------------------------------------------
// afdr_pkg
// shared widths, payload types and divider step functions for the
// aspect fit display rectangle unit
// ----------------------------------------------------------------------------
package afdr_pkg;

    localparam int DIM_BITS   = 14;
    localparam int SAR_BITS   = 16;
    localparam int POS_BITS   = DIM_BITS + 1;
    localparam int PROD_BITS  = SAR_BITS + DIM_BITS;
    localparam int MUL_BITS   = DIM_BITS + PROD_BITS;
    localparam int DIV_BITS   = MUL_BITS + 1;
    localparam int DIV_STEPS  = DIM_BITS;
    localparam int PIPE_DEPTH = DIV_STEPS + 5;

    typedef logic [DIM_BITS-1:0]  dim_t;
    typedef logic [SAR_BITS-1:0]  sar_t;
    typedef logic [POS_BITS-1:0]  pos_t;
    typedef logic [PROD_BITS-1:0] prod_t;
    typedef logic [MUL_BITS-1:0]  mul_t;
    typedef logic [DIV_BITS-1:0]  dvd_t;

    // area geometry carried alongside the arithmetic
    typedef struct packed {
        dim_t origin_x;
        dim_t origin_y;
        dim_t area_width;
        dim_t area_height;
    } geo_t;

    // one lane of the restoring divider, quotient limited to DIM_BITS bits
    typedef struct packed {
        prod_t rem;
        dim_t  low;
        dim_t  quo;
        prod_t dvs;
        logic  ovf;
    } div_lane_t;

    // quotient of at least 2**DIM_BITS is flagged as overflow
    function automatic div_lane_t div_init(dvd_t dvd, prod_t dvs);
        div_lane_t                 lane;
        logic [PROD_BITS:0]        head;
        head     = dvd[DIV_BITS-1:DIM_BITS];
        lane.ovf = (head >= {1'b0, dvs});
        lane.rem = lane.ovf ? '0 : head[PROD_BITS-1:0];
        lane.low = dvd[DIM_BITS-1:0];
        lane.quo = '0;
        lane.dvs = dvs;
        return lane;
    endfunction

    // one quotient bit per call
    function automatic div_lane_t div_step(div_lane_t lane);
        div_lane_t          nxt;
        logic [PROD_BITS:0] trial;
        logic [PROD_BITS:0] diff;
        logic               qbit;
        nxt   = lane;
        trial = {lane.rem, lane.low[DIM_BITS-1]};
        diff  = trial - {1'b0, lane.dvs};
        qbit  = (trial >= {1'b0, lane.dvs});
        if (qbit)
        begin
            nxt.rem = diff[PROD_BITS-1:0];
        end
        else
        begin
            nxt.rem = trial[PROD_BITS-1:0];
        end
        nxt.quo = {lane.quo[DIM_BITS-2:0], qbit};
        nxt.low = {lane.low[DIM_BITS-2:0], 1'b0};
        return nxt;
    endfunction

endpackage

// File: src/afdr_req_if.sv
// ----------------------------------------------------------------------------
// afdr_req_if
// request channel: display area, picture size and sample aspect ratio
// ----------------------------------------------------------------------------
interface afdr_req_if;

    logic               valid;
    logic               ready;
    afdr_pkg::dim_t     origin_x;
    afdr_pkg::dim_t     origin_y;
    afdr_pkg::dim_t     area_width;
    afdr_pkg::dim_t     area_height;
    afdr_pkg::dim_t     picture_width;
    afdr_pkg::dim_t     picture_height;
    afdr_pkg::sar_t     sar_numerator;
    afdr_pkg::sar_t     sar_denominator;

    modport source (
        output valid, origin_x, origin_y, area_width, area_height,
               picture_width, picture_height, sar_numerator, sar_denominator,
        input  ready
    );

    modport sink (
        input  valid, origin_x, origin_y, area_width, area_height,
               picture_width, picture_height, sar_numerator, sar_denominator,
        output ready
    );

endinterface

// File: src/afdr_rsp_if.sv
// ----------------------------------------------------------------------------
// afdr_rsp_if
// result channel: fitted picture rectangle
// ----------------------------------------------------------------------------
interface afdr_rsp_if;

    logic               valid;
    logic               ready;
    afdr_pkg::pos_t     rect_x;
    afdr_pkg::pos_t     rect_y;
    afdr_pkg::dim_t     rect_width;
    afdr_pkg::dim_t     rect_height;

    modport source (
        output valid, rect_x, rect_y, rect_width, rect_height,
        input  ready
    );

    modport sink (
        input  valid, rect_x, rect_y, rect_width, rect_height,
        output ready
    );

endinterface

// File: src/aspect_fit_display_rect_unit.sv
// ----------------------------------------------------------------------------
// aspect_fit_display_rect_unit
// pipeline: PIPE_DEPTH stages from request transfer to result valid
// throughput: one request per cycle while the skid register is empty, the dividers being one bit per stage
// reset: async active-low clears stage valid bits and the skid flag only
// ----------------------------------------------------------------------------
module aspect_fit_display_rect_unit (
    input  logic         clk,
    input  logic         rst_n,
    afdr_req_if.sink     req,
    afdr_rsp_if.source   rsp
);

    localparam int LAST   = afdr_pkg::PIPE_DEPTH - 1;
    localparam int GEO_HI = afdr_pkg::DIV_STEPS + 3;

    // pipeline map
    //   stage 0      : sar normalise, num = sar_num * pic_w, den = sar_den * pic_h
    //   stage 1      : ah * num and aw * den
    //   stage 2      : add half divisor for round to nearest
    //   stage 3      : divider set-up and overflow check (quotient >= 2**DIM_BITS)
    //   stages 4..17 : one quotient bit per stage, both divisions side by side
    //   stage 18     : fit choice, evening, clamps, minimum size of one and centring offsets
    // a skid register behind the last stage keeps req.ready off rsp.ready

    logic [LAST:0]          v_reg;
    logic                   en;
    logic                   skid_full_reg;
    logic                   skid_full_next;

    afdr_pkg::geo_t         geo_reg [0:GEO_HI];

    afdr_pkg::prod_t        num0_reg, den0_reg;
    afdr_pkg::prod_t        num1_reg, den1_reg;
    afdr_pkg::mul_t         pw1_reg, ph1_reg;
    afdr_pkg::dvd_t         dw2_reg, dh2_reg;
    afdr_pkg::prod_t        num2_reg, den2_reg;

    afdr_pkg::div_lane_t    wl_reg [0:afdr_pkg::DIV_STEPS];
    afdr_pkg::div_lane_t    hl_reg [0:afdr_pkg::DIV_STEPS];

    afdr_pkg::pos_t         rx_reg, ry_reg;
    afdr_pkg::dim_t         rw_reg, rh_reg;
    afdr_pkg::pos_t         sx_reg, sy_reg;
    afdr_pkg::dim_t         sw_reg, sh_reg;

    // stage 0 combinational
    logic                   square;
    afdr_pkg::sar_t         sn_eff, sd_eff;
    afdr_pkg::prod_t        num_next, den_next;
    afdr_pkg::geo_t         geo_in;

    // final stage combinational
    afdr_pkg::geo_t         gf;
    afdr_pkg::div_lane_t    wl, hl;
    afdr_pkg::dim_t         w_even, h_even, h_fit;
    afdr_pkg::dim_t         fit_w, fit_h;
    logic                   too_wide;
    afdr_pkg::pos_t         rx_next, ry_next;
    afdr_pkg::dim_t         rw_next, rh_next;

    // whole pipeline freezes only while the skid register holds a result
    assign en        = !skid_full_reg;
    assign req.ready = en;

    // zero numerator or denominator means square pixels
    always_comb
    begin
        square   = (req.sar_numerator == '0) || (req.sar_denominator == '0);
        sn_eff   = square ? afdr_pkg::sar_t'(1) : req.sar_numerator;
        sd_eff   = square ? afdr_pkg::sar_t'(1) : req.sar_denominator;
        num_next = afdr_pkg::PROD_BITS'(sn_eff) * afdr_pkg::PROD_BITS'(req.picture_width);
        den_next = afdr_pkg::PROD_BITS'(sd_eff) * afdr_pkg::PROD_BITS'(req.picture_height);
        geo_in.origin_x    = req.origin_x;
        geo_in.origin_y    = req.origin_y;
        geo_in.area_width  = req.area_width;
        geo_in.area_height = req.area_height;
    end

    // fit decision
    always_comb
    begin
        gf       = geo_reg[GEO_HI];
        wl       = wl_reg[afdr_pkg::DIV_STEPS];
        hl       = hl_reg[afdr_pkg::DIV_STEPS];
        w_even   = {wl.quo[afdr_pkg::DIM_BITS-1:1], 1'b0};
        h_even   = {hl.quo[afdr_pkg::DIM_BITS-1:1], 1'b0};
        // infinite ratio (zero den) or full-height width beyond the area
        too_wide = (wl.dvs == '0) || wl.ovf || (w_even > gf.area_width);
        // zero num gives zero height, overflow or oversize clamps to area
        if (hl.dvs == '0)
        begin
            h_fit = '0;
        end
        else if (hl.ovf || (h_even > gf.area_height))
        begin
            h_fit = gf.area_height;
        end
        else
        begin
            h_fit = h_even;
        end
        fit_w   = too_wide ? gf.area_width : w_even;
        fit_h   = too_wide ? h_fit : gf.area_height;
        // offsets use the size before the minimum of one
        rx_next = afdr_pkg::pos_t'(gf.origin_x)
                + afdr_pkg::pos_t'((gf.area_width - fit_w) >> 1);
        ry_next = afdr_pkg::pos_t'(gf.origin_y)
                + afdr_pkg::pos_t'((gf.area_height - fit_h) >> 1);
        rw_next = (fit_w == '0) ? afdr_pkg::dim_t'(1) : fit_w;
        rh_next = (fit_h == '0) ? afdr_pkg::dim_t'(1) : fit_h;
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[LAST-1:0], req.valid};
        end
    end

    // payload stages, no reset
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num0_reg   <= num_next;
            den0_reg   <= den_next;
            geo_reg[0] <= geo_in;

            pw1_reg    <= afdr_pkg::MUL_BITS'(geo_reg[0].area_height)
                        * afdr_pkg::MUL_BITS'(num0_reg);
            ph1_reg    <= afdr_pkg::MUL_BITS'(geo_reg[0].area_width)
                        * afdr_pkg::MUL_BITS'(den0_reg);
            num1_reg   <= num0_reg;
            den1_reg   <= den0_reg;

            dw2_reg    <= afdr_pkg::DIV_BITS'(pw1_reg)
                        + afdr_pkg::DIV_BITS'(den1_reg >> 1);
            dh2_reg    <= afdr_pkg::DIV_BITS'(ph1_reg)
                        + afdr_pkg::DIV_BITS'(num1_reg >> 1);
            num2_reg   <= num1_reg;
            den2_reg   <= den1_reg;

            wl_reg[0]  <= afdr_pkg::div_init(dw2_reg, den2_reg);
            hl_reg[0]  <= afdr_pkg::div_init(dh2_reg, num2_reg);

            for (int k = 1; k <= GEO_HI; k++)
            begin
                geo_reg[k] <= geo_reg[k-1];
            end
            for (int k = 1; k <= afdr_pkg::DIV_STEPS; k++)
            begin
                wl_reg[k] <= afdr_pkg::div_step(wl_reg[k-1]);
                hl_reg[k] <= afdr_pkg::div_step(hl_reg[k-1]);
            end

            rx_reg <= rx_next;
            ry_reg <= ry_next;
            rw_reg <= rw_next;
            rh_reg <= rh_next;
        end
    end

    // skid: catch the last-stage result when it is about to be overwritten
    always_comb
    begin
        if (skid_full_reg)
        begin
            skid_full_next = !rsp.ready;
        end
        else
        begin
            skid_full_next = v_reg[LAST] && !rsp.ready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_full_reg <= 1'b0;
        end
        else
        begin
            skid_full_reg <= skid_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!skid_full_reg && v_reg[LAST] && !rsp.ready)
        begin
            sx_reg <= rx_reg;
            sy_reg <= ry_reg;
            sw_reg <= rw_reg;
            sh_reg <= rh_reg;
        end
    end

    // skid holds the older result, so it goes out first
    assign rsp.valid       = skid_full_reg || v_reg[LAST];
    assign rsp.rect_x      = skid_full_reg ? sx_reg : rx_reg;
    assign rsp.rect_y      = skid_full_reg ? sy_reg : ry_reg;
    assign rsp.rect_width  = skid_full_reg ? sw_reg : rw_reg;
    assign rsp.rect_height = skid_full_reg ? sh_reg : rh_reg;

`ifndef SYNTHESIS
    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        skid_full_reg |=> $stable(v_reg))
        else $error("pipeline moved while skid register was full");

    a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        skid_full_reg && !rsp.ready |=> skid_full_reg && rsp.valid)
        else $error("skid result lost while result side stalled");

    a_req_enters: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> v_reg[0])
        else $error("accepted request did not enter stage 0");

    a_min_size: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.rect_width != '0) && (rsp.rect_height != '0))
        else $error("fitted rectangle has zero size");
`endif

endmodule
